// ----- rtl/core/lhws_pkg.sv -----
// line hash package: payload types, character codes and white_mode codes
// used by the channel interfaces and by line_hash_whitespace_modes_top
// no dependencies
package lhws_pkg;

	// payload field types
	typedef logic [7:0]         byte_t;
	typedef logic signed [16:0] hash_t;
	typedef logic [11:0]        len_t;
	typedef logic [1:0]         wmode_t;
	typedef logic [3:0]         shamt_t;

	// default maximum line length, including the stored newline slot
	localparam int MAX_LINE_DEF = 4096;

	// character codes
	localparam byte_t CH_NEWLINE = 8'h0A;
	localparam byte_t CH_SPACE   = 8'h20;
	localparam byte_t CH_WS_LO   = 8'h09;
	localparam byte_t CH_WS_HI   = 8'h0D;

	// shift advance per kept byte
	localparam shamt_t SHIFT_STEP = 4'd7;

	// running sum value at the start of a line
	localparam logic [31:0] SUM_INIT = 32'd1;

	// white_mode codes; the unused code behaves as strip
	localparam wmode_t WM_ALL      = 2'd0;
	localparam wmode_t WM_COALESCE = 2'd1;
	localparam wmode_t WM_STRIP    = 2'd2;

endpackage

// ----- rtl/core/lhws_if.sv -----
// valid/ready channel interfaces for the line hash block
// depends on lhws_pkg for the payload types
interface lhws_in_if import lhws_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t byte_value;
	logic  end_of_input;

	modport source (output valid, output byte_value, output end_of_input, input ready);
	modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface lhws_out_if import lhws_pkg::*; ();
	logic  valid;
	logic  ready;
	hash_t line_hash;
	len_t  stored_length;

	modport source (output valid, output line_hash, output stored_length, input ready);
	modport sink   (input valid, input line_hash, input stored_length, output ready);
endinterface

// ----- rtl/core/line_hash_whitespace_modes_top.sv -----
// line hash for diff matching: one byte per item in, one folded hash per line out
// depends on lhws_pkg and on the lhws_in_if / lhws_out_if channel interfaces
//
// usage
//   in_item carries byte_value and end_of_input; out_item carries line_hash
//   and stored_length. both are valid/ready channels, an item moves when
//   valid and ready are high at a rising clk edge.
//   cfg_we/cfg_data write white_mode; write it only while the block is idle.
//   a result appears for each newline and for end_of_input after a partial
//   line; an end_of_input with nothing pending gives no result.
// timing
//   one item per cycle sustained while out_item is not stalled. an accepted
//   item sits in the input stage and is hashed into the result register
//   when it advances. the per-byte sum update and the fold form the longest
//   path (32-bit add then 17-bit fold).
// reset and stall
//   arst_n clears both stages, white_mode to hash-all, and the line state
//   (sum 1, shift 0). when out_item is stalled the result register holds and
//   the input stage fills; in_item.ready drops only when both are full.
module line_hash_whitespace_modes_top
	import lhws_pkg::*;
#(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  wmode_t            cfg_data,
	lhws_in_if.sink           in_item,
	lhws_out_if.source        out_item
);

	localparam int CNT_W = $clog2(MAX_LINE);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LINE - 1);

	// fold: low16 + signed high16, then once more with the floor of the carry
	function automatic hash_t fold_sum(input logic [31:0] sum);
		logic signed [17:0] s;
		logic signed [17:0] r;
		s = $signed({2'b00, sum[15:0]}) + 18'(signed'(sum[31:16]));
		r = 18'(signed'(s[15:0])) + (s >>> 16);
		return hash_t'(r);
	endfunction

	// configuration register
	wmode_t wmode_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmode_q <= WM_ALL;
		end else if (cfg_we) begin
			wmode_q <= cfg_data;
		end
	end

	// input stage
	logic  valid_s1;
	byte_t byte_s1;
	logic  eoi_s1;
	logic  out_valid_q;
	logic  advance;

	assign advance       = valid_s1 && (!out_valid_q || out_item.ready);
	assign in_item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_item.ready) begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			byte_s1 <= in_item.byte_value;
			eoi_s1  <= in_item.end_of_input;
		end
	end

	// line state
	logic [31:0]      sum_q;
	shamt_t           shift_q;
	logic             space_q;
	logic [CNT_W-1:0] count_q;
	logic             discard_q;

	// per-byte hash logic
	logic             is_white;
	logic             keep;
	shamt_t           shift_eff;
	logic [31:0]      sum_add;
	logic [CNT_W-1:0] count_inc;
	logic             is_nl;

	assign is_white  = (byte_s1 == CH_SPACE) || (byte_s1 >= CH_WS_LO && byte_s1 <= CH_WS_HI);
	assign keep      = (wmode_q == WM_ALL) || !is_white;
	assign shift_eff = (wmode_q == WM_COALESCE && space_q) ? shift_q + SHIFT_STEP : shift_q;
	assign sum_add   = sum_q + ({24'd0, byte_s1} << shift_eff);
	assign count_inc = count_q + 1'b1;
	assign is_nl     = (byte_s1 == CH_NEWLINE);

	// next state and result selection
	logic             emit;
	hash_t            emit_hash;
	len_t             emit_len;
	logic             clear;
	logic [31:0]      sum_d;
	shamt_t           shift_d;
	logic             space_d;
	logic [CNT_W-1:0] count_d;
	logic             discard_d;

	always_comb begin
		emit      = 1'b0;
		emit_hash = fold_sum(sum_q);
		emit_len  = len_t'(count_q);
		clear     = 1'b0;
		sum_d     = sum_q;
		shift_d   = shift_q;
		space_d   = space_q;
		count_d   = count_q;
		discard_d = discard_q;
		if (eoi_s1) begin
			emit  = (count_q != '0) || discard_q;
			clear = 1'b1;
		end else if (discard_q) begin
			emit  = is_nl;
			clear = is_nl;
		end else begin
			// hash one byte
			if (keep) begin
				sum_d   = sum_add;
				shift_d = shift_eff + SHIFT_STEP;
			end
			if (wmode_q != WM_ALL) begin
				space_d = is_white;
			end
			count_d = count_inc;
			if (is_nl) begin
				emit      = 1'b1;
				emit_hash = fold_sum(sum_d);
				emit_len  = len_t'(count_inc);
				clear     = 1'b1;
			end else if (count_inc >= CNT_FULL) begin
				discard_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= SUM_INIT;
			shift_q   <= '0;
			space_q   <= 1'b0;
			count_q   <= '0;
			discard_q <= 1'b0;
		end else if (advance) begin
			if (clear) begin
				sum_q     <= SUM_INIT;
				shift_q   <= '0;
				space_q   <= 1'b0;
				count_q   <= '0;
				discard_q <= 1'b0;
			end else begin
				sum_q     <= sum_d;
				shift_q   <= shift_d;
				space_q   <= space_d;
				count_q   <= count_d;
				discard_q <= discard_d;
			end
		end
	end

	// result register
	hash_t hash_q;
	len_t  len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			hash_q <= emit_hash;
			len_q  <= emit_len;
		end
	end

	assign out_item.valid         = out_valid_q;
	assign out_item.line_hash     = hash_q;
	assign out_item.stored_length = len_q;

	// checks
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eoi_s1) |=> (count_q == '0 && sum_q == SUM_INIT && !discard_q))
		else $error("line state not cleared after end of input");

	a_discard_full: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> (count_q == CNT_FULL))
		else $error("discarding with a line that is not full");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result appeared without a processed item");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(eoi_s1)))
		else $error("input stage lost an item while stalled");

endmodule

// ----- tb/sv/tb_line_hash_whitespace_modes_top.sv -----
// self-checking testbench for line_hash_whitespace_modes_top: byte stream in,
// one folded line hash out, checked against an in-bench line hash predictor
// depends on lhws_pkg, lhws_in_if / lhws_out_if and the top level rtl
module tb_line_hash_whitespace_modes_top;
	import lhws_pkg::*;

	localparam int     LINE_LIMIT       = MAX_LINE_DEF;
	localparam int     PHASES           = 8;
	localparam int     RANDOM_PER_PHASE = 200;
	localparam int     IDLE_HEAVY       = 53;
	localparam int     IDLE_LIGHT       = 7;
	localparam int     SETTLE_CYCLES    = 8;
	localparam int     CYCLE_LIMIT      = 1000000;
	localparam wmode_t WM_SPARE         = 2'd3;

	typedef struct packed {
		byte_t byte_value;
		logic  end_of_input;
	} stream_item_t;

	typedef struct packed {
		hash_t line_hash;
		len_t  stored_length;
	} line_result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	// block inputs, known from time zero
	logic   cfg_we    = 1'b0;
	wmode_t cfg_data  = WM_ALL;
	logic   drv_valid = 1'b0;
	byte_t  drv_byte  = '0;
	logic   drv_eoi   = 1'b0;
	logic   mon_ready = 1'b0;

	lhws_in_if  in_item ();
	lhws_out_if out_item ();

	assign in_item.valid        = drv_valid;
	assign in_item.byte_value   = drv_byte;
	assign in_item.end_of_input = drv_eoi;
	assign out_item.ready       = mon_ready;

	line_hash_whitespace_modes_top #(
		.MAX_LINE(LINE_LIMIT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_item  (in_item),
		.out_item (out_item)
	);

	// stimulus and expected line hashes
	stream_item_t pending_bytes [$];
	line_result_t expected_lines [$];
	int pushed_total   = 0;
	int accepted_total = 0;
	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// predictor line state
	wmode_t      pred_mode = WM_ALL;
	logic [31:0] ln_sum;
	shamt_t      ln_shift;
	logic        ln_in_run;
	int          ln_count;
	logic        ln_discard;

	task automatic clear_line_state();
		ln_sum     = SUM_INIT;
		ln_shift   = '0;
		ln_in_run  = 1'b0;
		ln_count   = 0;
		ln_discard = 1'b0;
	endtask

	// low half plus signed high half, then the same once more
	function automatic hash_t fold_line_sum(logic [31:0] sum);
		int lo_half;
		int hi_half;
		int partial;
		int folded;
		lo_half = int'({16'b0, sum[15:0]});
		hi_half = int'({{16{sum[31]}}, sum[31:16]});
		partial = lo_half + hi_half;
		folded  = int'({{16{partial[15]}}, partial[15:0]});
		folded  = folded + ((partial < 0) ? -1 : (partial >>> 16));
		return hash_t'(folded);
	endfunction

	task automatic finish_line();
		line_result_t res;
		res.line_hash     = fold_line_sum(ln_sum);
		res.stored_length = len_t'(ln_count);
		expected_lines.push_back(res);
		clear_line_state();
	endtask

	task automatic add_to_sum(input byte_t b);
		ln_sum   = ln_sum + ({24'b0, b} << ln_shift);
		ln_shift = ln_shift + SHIFT_STEP;
	endtask

	// one accepted item through the line hash
	task automatic hash_item(input byte_t b, input logic eoi);
		if (eoi) begin
			if (ln_count > 0 || ln_discard)
				finish_line();
			else
				clear_line_state();
		end else if (ln_discard) begin
			if (b == CH_NEWLINE)
				finish_line();
		end else begin
			if (pred_mode == WM_ALL) begin
				add_to_sum(b);
			end else if (b == CH_SPACE || (b >= CH_WS_LO && b <= CH_WS_HI)) begin
				ln_in_run = 1'b1;
			end else begin
				// coalesce: one shift step for the whole whitespace run
				if (pred_mode == WM_COALESCE && ln_in_run)
					ln_shift = ln_shift + SHIFT_STEP;
				ln_in_run = 1'b0;
				add_to_sum(b);
			end
			ln_count++;
			if (b == CH_NEWLINE)
				finish_line();
			else if (ln_count >= LINE_LIMIT - 1)
				ln_discard = 1'b1;
		end
	endtask

	// stimulus helpers
	task automatic push_item(input byte_t b, input logic eoi);
		pending_bytes.push_back('{byte_value: b, end_of_input: eoi});
		pushed_total++;
	endtask

	// text byte with plenty of whitespace, never a newline
	function automatic byte_t random_text_byte();
		int    pick;
		int    ws_pick;
		byte_t b;
		pick = $urandom_range(99);
		if (pick < 35) begin
			ws_pick = $urandom_range(5);
			b = (ws_pick == 5) ? CH_SPACE : byte_t'(CH_WS_LO + ws_pick);
			if (b == CH_NEWLINE)
				b = CH_SPACE;
		end else if (pick < 85) begin
			b = byte_t'($urandom_range(8'h7E, 8'h21));
		end else begin
			b = byte_t'($urandom_range(255));
			if (b == CH_NEWLINE)
				b = 8'h8A;
		end
		return b;
	endfunction

	task automatic push_random_line();
		int body_len;
		int term;
		body_len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(24);
		repeat (body_len) push_item(random_text_byte(), 1'b0);
		term = $urandom_range(99);
		if (term < 88) begin
			push_item(CH_NEWLINE, 1'b0);
		end else if (term < 96) begin
			push_item(byte_t'($urandom_range(255)), 1'b1);
		end else begin
			// end of input twice: the second has nothing pending
			push_item(byte_t'($urandom_range(255)), 1'b1);
			push_item(byte_t'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic wait_until_drained();
		while (accepted_total != pushed_total || expected_lines.size() != 0)
			@(posedge clk);
	endtask

	// input driver: predicts on every accepted item
	always @(posedge clk) begin
		stream_item_t next_item;
		if (arst_n) begin
			if (drv_valid && in_item.ready) begin
				hash_item(drv_byte, drv_eoi);
				accepted_total++;
			end
			if (!drv_valid || in_item.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_bytes.pop_front();
					drv_valid <= 1'b1;
					drv_byte  <= next_item.byte_value;
					drv_eoi   <= next_item.end_of_input;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: compare against the oldest expected line
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n) begin
			if (out_item.valid && mon_ready) begin
				if (expected_lines.size() == 0) begin
					$error("unexpected line result: line_hash %0d stored_length %0d",
						out_item.line_hash, out_item.stored_length);
					error_count++;
				end else begin
					want = expected_lines.pop_front();
					if (out_item.line_hash !== want.line_hash) begin
						$error("line_hash: expected %0d, actual %0d",
							want.line_hash, out_item.line_hash);
						error_count++;
					end
					if (out_item.stored_length !== want.stored_length) begin
						$error("stored_length: expected %0d, actual %0d",
							want.stored_length, out_item.stored_length);
						error_count++;
					end
				end
			end
			mon_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// reset, then phases that each set a white_mode and an idle pattern
	initial begin : sequencer
		int pattern;
		int phase_start;
		clear_line_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
			wait_until_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);

			// white_mode write while idle
			case (phase_idx % 4)
				0:       pred_mode = WM_ALL;
				1:       pred_mode = WM_COALESCE;
				2:       pred_mode = WM_STRIP;
				default: pred_mode = WM_SPARE;
			endcase
			cfg_data <= pred_mode;
			cfg_we   <= 1'b1;
			@(posedge clk);
			cfg_we   <= 1'b0;

			pattern = (phase_idx + phase_idx / 4) % 4;
			case (pattern)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = IDLE_HEAVY;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = IDLE_HEAVY;
				end
				default: begin
					send_idle_pct  = IDLE_LIGHT;
					recv_stall_pct = IDLE_LIGHT;
				end
			endcase

			// directed: empty stream end, empty line, byte extremes, whitespace
			if (phase_idx == 0) begin
				push_item(8'hFF, 1'b1);
				push_item(CH_NEWLINE, 1'b0);
				push_item(8'h00, 1'b0);
				push_item(8'hFF, 1'b0);
				push_item(8'h7F, 1'b0);
				push_item(8'h80, 1'b0);
				push_item(CH_NEWLINE, 1'b0);
				push_item(CH_SPACE, 1'b0);
				push_item(CH_WS_LO, 1'b0);
				push_item(CH_WS_HI, 1'b0);
				push_item(8'h61, 1'b0);
				push_item(8'h0B, 1'b0);
				push_item(8'h0C, 1'b0);
				push_item(CH_NEWLINE, 1'b0);
				push_item(8'hFF, 1'b0);
				push_item(8'hFF, 1'b0);
				push_item(8'hFF, 1'b0);
				push_item(8'h00, 1'b1);
				push_item(8'h00, 1'b1);
				push_item(8'h01, 1'b0);
				push_item(CH_NEWLINE, 1'b0);
			end

			phase_start = pushed_total;
			while (pushed_total - phase_start < RANDOM_PER_PHASE)
				push_random_line();
			push_item(8'h00, 1'b1);
		end

		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
